// ----- rtl/tsvfs_pkg.sv -----
// Shared constants and types of the tab-separated field splitter.
package tsvfs_pkg;

    localparam logic [7:0] CH_TAB   = 8'd9;
    localparam logic [7:0] CH_NL    = 8'd10;
    localparam logic [7:0] CH_QUOTE = 8'd34;

    localparam logic [1:0] KIND_DATA      = 2'd0;
    localparam logic [1:0] KIND_FIELD_END = 2'd1;
    localparam logic [1:0] KIND_LINE_END  = 2'd2;
    localparam logic [1:0] KIND_REJECT    = 2'd3;

    localparam int MAX_FIELDS_DEFAULT = 256;
    localparam int WIDTH_BITS_DEFAULT = 16;
    localparam int QUEUE_DEPTH        = 2;

    localparam int OUT_TDATA_W = 80;
    localparam int OUT_TUSER_W = 3;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  out_byte;
        logic [7:0]  field_number;
        logic [15:0] width;
        logic        quoted;
        logic [8:0]  field_count;
        logic        is_header;
        logic [31:0] line_number;
    } result_t;

endpackage

// ----- rtl/tsvfs_front.sv -----
// Input stage: accepts bytes and drops the repeated quotes of a quote run.
module tsvfs_front
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] in_byte,
    output logic       push_valid,
    input  logic       push_ready,
    output logic [7:0] push_byte
);

    logic quote_run_reg;
    logic quote_run_next;
    logic is_quote;
    logic accept;

    assign is_quote   = (in_byte == tsvfs_pkg::CH_QUOTE);
    assign in_ready   = push_ready;
    assign accept     = in_valid && push_ready;
    assign push_valid = in_valid && !(is_quote && quote_run_reg);
    assign push_byte  = in_byte;

    always_comb
    begin
        quote_run_next = quote_run_reg;
        if (accept)
        begin
            quote_run_next = is_quote;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            quote_run_reg <= 1'b0;
        end
        else
        begin
            quote_run_reg <= quote_run_next;
        end
    end

endmodule

// ----- rtl/tsvfs_queue.sv -----
// Short byte queue between the input stage and the field tracker.
module tsvfs_queue
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       wr_valid,
    output logic       wr_ready,
    input  logic [7:0] wr_data,
    output logic       rd_valid,
    input  logic       rd_ready,
    output logic [7:0] rd_data
);

    localparam int DEPTH = tsvfs_pkg::QUEUE_DEPTH;
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [7:0]       entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             push;
    logic             pop;

    assign wr_ready = (count_reg != CNT_W'(DEPTH));
    assign rd_valid = (count_reg != CNT_W'(0));
    assign rd_data  = entry_reg[rd_ptr_reg];
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_valid && rd_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? PTR_W'(0)
                                                            : wr_ptr_reg + PTR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? PTR_W'(0)
                                                            : rd_ptr_reg + PTR_W'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

// ----- rtl/tsvfs_back.sv -----
// Field and line tracker: widths, quote flags, field counts and the output register.
module tsvfs_back
#(
    parameter int MAX_FIELDS = tsvfs_pkg::MAX_FIELDS_DEFAULT,
    parameter int WIDTH_BITS = tsvfs_pkg::WIDTH_BITS_DEFAULT
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                save_header,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [7:0]          in_byte,
    output logic                res_valid,
    input  logic                res_ready,
    output tsvfs_pkg::result_t  res
);

    localparam int FI_W = $clog2(MAX_FIELDS + 1);
    localparam logic [WIDTH_BITS-1:0] WIDTH_MAX = {WIDTH_BITS{1'b1}};

    logic [WIDTH_BITS-1:0] cur_width_reg;
    logic [WIDTH_BITS-1:0] cur_width_next;
    logic                  starts_quote_reg;
    logic                  starts_quote_next;
    logic                  ends_quote_reg;
    logic                  ends_quote_next;
    logic [FI_W-1:0]       field_index_reg;
    logic [FI_W-1:0]       field_index_next;
    logic [FI_W-1:0]       expected_reg;
    logic [FI_W-1:0]       expected_next;
    logic [31:0]           line_reg;
    logic [31:0]           line_next;
    logic                  halted_reg;
    logic                  halted_next;
    logic                  valid_reg;
    logic                  valid_next;
    tsvfs_pkg::result_t    res_reg;
    tsvfs_pkg::result_t    res_next;

    logic                  pop;
    logic                  work;
    logic                  is_tab;
    logic                  is_nl;
    logic                  is_quote;
    logic                  header;
    logic                  quoted;
    logic [WIDTH_BITS-1:0] stripped;
    logic                  too_many;
    logic [FI_W-1:0]       count;
    logic                  reject;
    logic [FI_W+8:0]       index_ext;
    logic [FI_W+8:0]       count_ext;
    logic [WIDTH_BITS+15:0] width_ext;

    assign in_ready  = !valid_reg || res_ready;
    assign pop       = in_valid && in_ready;
    assign work      = pop && !halted_reg;
    assign res_valid = valid_reg;
    assign res       = res_reg;

    assign is_tab   = (in_byte == tsvfs_pkg::CH_TAB);
    assign is_nl    = (in_byte == tsvfs_pkg::CH_NL);
    assign is_quote = (in_byte == tsvfs_pkg::CH_QUOTE);
    assign header   = save_header && (line_reg == 32'd0);

    assign quoted   = starts_quote_reg && ends_quote_reg
                      && (cur_width_reg >= WIDTH_BITS'(2));
    assign stripped = quoted ? cur_width_reg - WIDTH_BITS'(2) : cur_width_reg;
    assign too_many = (field_index_reg >= FI_W'(MAX_FIELDS));
    assign count    = too_many ? FI_W'(MAX_FIELDS) : field_index_reg + FI_W'(1);
    assign reject   = too_many || ((expected_reg != FI_W'(0)) && (count != expected_reg));

    assign index_ext = (FI_W + 9)'(field_index_reg);
    assign count_ext = (FI_W + 9)'(count);
    assign width_ext = (WIDTH_BITS + 16)'(stripped);

    always_comb
    begin
        cur_width_next    = cur_width_reg;
        starts_quote_next = starts_quote_reg;
        ends_quote_next   = ends_quote_reg;
        field_index_next  = field_index_reg;
        expected_next     = expected_reg;
        line_next         = line_reg;
        halted_next       = halted_reg;

        res_next              = '0;
        res_next.field_number = index_ext[7:0];
        res_next.is_header    = header;
        res_next.line_number  = line_reg;

        if (work)
        begin
            if (is_tab)
            begin
                res_next.kind   = tsvfs_pkg::KIND_FIELD_END;
                res_next.width  = width_ext[15:0];
                res_next.quoted = quoted;
                if (!too_many)
                begin
                    field_index_next = field_index_reg + FI_W'(1);
                end
                cur_width_next    = '0;
                starts_quote_next = 1'b0;
                ends_quote_next   = 1'b0;
            end
            else if (is_nl)
            begin
                res_next.field_count = count_ext[8:0];
                if (reject)
                begin
                    res_next.kind      = tsvfs_pkg::KIND_REJECT;
                    res_next.is_header = 1'b0;
                    halted_next        = 1'b1;
                end
                else
                begin
                    res_next.kind   = tsvfs_pkg::KIND_LINE_END;
                    res_next.width  = width_ext[15:0];
                    res_next.quoted = quoted;
                    if (expected_reg == FI_W'(0))
                    begin
                        expected_next = count;
                    end
                    field_index_next  = '0;
                    cur_width_next    = '0;
                    starts_quote_next = 1'b0;
                    ends_quote_next   = 1'b0;
                    if (line_reg != 32'hFFFF_FFFF)
                    begin
                        line_next = line_reg + 32'd1;
                    end
                end
            end
            else
            begin
                res_next.kind     = tsvfs_pkg::KIND_DATA;
                res_next.out_byte = in_byte;
                if (cur_width_reg == WIDTH_BITS'(0))
                begin
                    starts_quote_next = is_quote;
                end
                ends_quote_next = is_quote;
                if (cur_width_reg != WIDTH_MAX)
                begin
                    cur_width_next = cur_width_reg + WIDTH_BITS'(1);
                end
            end
        end

        if (work)
        begin
            valid_next = 1'b1;
        end
        else if (res_ready)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_width_reg    <= '0;
            starts_quote_reg <= 1'b0;
            ends_quote_reg   <= 1'b0;
            field_index_reg  <= '0;
            expected_reg     <= '0;
            line_reg         <= '0;
            halted_reg       <= 1'b0;
            valid_reg        <= 1'b0;
        end
        else
        begin
            cur_width_reg    <= cur_width_next;
            starts_quote_reg <= starts_quote_next;
            ends_quote_reg   <= ends_quote_next;
            field_index_reg  <= field_index_next;
            expected_reg     <= expected_next;
            line_reg         <= line_next;
            halted_reg       <= halted_next;
            valid_reg        <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (work)
        begin
            res_reg <= res_next;
        end
    end

    // Once halted, the tracker stays halted until reset.
    assert property (@(posedge clk) disable iff (!rst_n) halted_reg |=> halted_reg)
        else $error("halt was released without reset");

    // The field index never runs past its saturation point.
    assert property (@(posedge clk) disable iff (!rst_n)
        field_index_reg <= FI_W'(MAX_FIELDS))
        else $error("field index beyond its limit");

    // A rejected line is always followed by the halted state.
    assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && (res_reg.kind == tsvfs_pkg::KIND_REJECT)) |-> halted_reg)
        else $error("reject shown without halting");

    // An accepted line end leaves the expected field count known.
    assert property (@(posedge clk) disable iff (!rst_n)
        (work && is_nl && !reject) |=> (expected_reg != FI_W'(0)))
        else $error("expected field count not set after a line end");

endmodule

// ----- rtl/tab_separated_field_splitter.sv -----
// Top level of the tab-separated field splitter: stream ports, register port and packing.
//
// The block takes one text byte per clock on the input stream, unless back-pressure on the
// result stream holds it, and gives at most one result transfer per byte: a data byte, a
// field end at a tab, a line end at a newline, or a line rejection after which every further
// byte is consumed without result until reset. Repeated quotes of a quote run are consumed
// without result. Throughput is one byte per cycle under the same condition; an input byte
// passes through the two-entry byte queue and then the output register of the field tracker,
// which also updates width, field index and line counter.
module tab_separated_field_splitter
#(
    parameter int MAX_FIELDS = tsvfs_pkg::MAX_FIELDS_DEFAULT,
    parameter int WIDTH_BITS = tsvfs_pkg::WIDTH_BITS_DEFAULT
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [2:0]                        paddr,
    input  logic [31:0]                       pwdata,
    output logic [31:0]                       prdata,
    output logic                              pready,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // Fields from bit 0: in_byte[7:0].
    input  logic [7:0]                        s_axis_tdata,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // Fields from bit 0: out_byte[7:0], field_number[15:8], width[31:16], quoted[32],
    // field_count[41:33], line_number[73:42], zero fill [79:74].
    output logic [tsvfs_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    // Fields from bit 0: kind[1:0], is_header[2].
    output logic [tsvfs_pkg::OUT_TUSER_W-1:0] m_axis_tuser
);

    logic               save_header_reg;
    logic               save_header_next;
    logic               q_wr_valid;
    logic               q_wr_ready;
    logic [7:0]         q_wr_data;
    logic               q_rd_valid;
    logic               q_rd_ready;
    logic [7:0]         q_rd_data;
    tsvfs_pkg::result_t res;
    logic               reg_hit;

    assign pready  = 1'b1;
    assign reg_hit = (paddr[2] == 1'b0);
    assign prdata  = reg_hit ? {31'd0, save_header_reg} : 32'd0;

    always_comb
    begin
        save_header_next = save_header_reg;
        if (psel && penable && pwrite && reg_hit)
        begin
            save_header_next = pwdata[0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            save_header_reg <= 1'b0;
        end
        else
        begin
            save_header_reg <= save_header_next;
        end
    end

    tsvfs_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .in_byte    (s_axis_tdata),
        .push_valid (q_wr_valid),
        .push_ready (q_wr_ready),
        .push_byte  (q_wr_data)
    );

    tsvfs_queue u_queue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (q_wr_valid),
        .wr_ready (q_wr_ready),
        .wr_data  (q_wr_data),
        .rd_valid (q_rd_valid),
        .rd_ready (q_rd_ready),
        .rd_data  (q_rd_data)
    );

    tsvfs_back
    #(
        .MAX_FIELDS (MAX_FIELDS),
        .WIDTH_BITS (WIDTH_BITS)
    )
    u_back
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .save_header (save_header_reg),
        .in_valid    (q_rd_valid),
        .in_ready    (q_rd_ready),
        .in_byte     (q_rd_data),
        .res_valid   (m_axis_tvalid),
        .res_ready   (m_axis_tready),
        .res         (res)
    );

    assign m_axis_tdata = {6'd0, res.line_number, res.field_count, res.quoted,
                           res.width, res.field_number, res.out_byte};
    assign m_axis_tuser = {res.is_header, res.kind};

endmodule

// ----- tb/sv/tb_tab_separated_field_splitter.sv -----
// Self-checking testbench of the tab-separated field splitter with a built-in predictor.
module tb_tab_separated_field_splitter;
    timeunit 1ns;
    timeprecision 1ps;

    import tsvfs_pkg::*;

    localparam int MAXF = MAX_FIELDS_DEFAULT;
    localparam int LINE_FIELDS = 4;
    localparam int PHASE_ITEMS = 365;
    localparam int HOLD_CYCLES = 300;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam logic [2:0] REG_SAVE_HEADER = 3'd0;
    localparam int IDLE_PCT [4] = '{0, 53, 0, 34};
    localparam int STALL_PCT [4] = '{0, 0, 53, 34};

    typedef enum logic [1:0] {ROW_BYTE, ROW_BYTE_LIT, ROW_CFG} row_op_t;

    typedef struct {
        row_op_t    op;
        logic [7:0] val;
        result_t    lit;
    } row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [2:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;
    logic s_axis_tvalid = 1'b0;
    logic s_axis_tready;
    logic [7:0] s_axis_tdata = '0;
    logic m_axis_tvalid;
    logic m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic [OUT_TUSER_W-1:0] m_axis_tuser;

    // Predictor state.
    logic        hdr_mode = 1'b0;
    logic        in_qrun = 1'b0;
    logic [15:0] fld_width = '0;
    logic        first_is_q = 1'b0;
    logic        last_is_q = 1'b0;
    logic [8:0]  fld_index = '0;
    logic [8:0]  line_fields = '0;
    logic [31:0] line_idx = '0;
    logic        stopped = 1'b0;

    result_t predicted_tokens [$];
    result_t got_r;
    result_t want_r;
    row_t dir_rows [$];
    int errors = 0;
    int sent_count = 0;
    int idle_pct = 0;
    int stall_pct = 0;
    int hold_requests = 0;
    int hold_served = 0;
    int hold_left = 0;
    int quiet_cycles = 0;

    tab_separated_field_splitter dut (.*);

    always #2 clk = ~clk;

    function automatic void clear_field();
        in_qrun = 1'b0;
        fld_width = '0;
        first_is_q = 1'b0;
        last_is_q = 1'b0;
    endfunction

    function automatic bit split_byte(input logic [7:0] c, output result_t r);
        logic hdr;
        logic q;
        logic [15:0] w;
        logic [8:0] cnt;
        bit too_many;
        hdr = hdr_mode && (line_idx == 0);
        r = '0;
        if (stopped)
            return 1'b0;
        if (c == CH_TAB || c == CH_NL)
        begin
            q = first_is_q && last_is_q && (fld_width >= 2);
            w = q ? fld_width - 16'd2 : fld_width;
            r.field_number = fld_index[7:0];
            r.line_number = line_idx;
            if (c == CH_TAB)
            begin
                r.kind = KIND_FIELD_END;
                r.width = w;
                r.quoted = q;
                r.is_header = hdr;
                if (fld_index < MAXF)
                    fld_index = fld_index + 9'd1;
                clear_field();
                return 1'b1;
            end
            too_many = fld_index >= MAXF;
            cnt = too_many ? 9'(MAXF) : fld_index + 9'd1;
            r.field_count = cnt;
            if (too_many || (line_fields != 0 && cnt != line_fields))
            begin
                r.kind = KIND_REJECT;
                stopped = 1'b1;
                return 1'b1;
            end
            if (line_fields == 0)
                line_fields = cnt;
            r.kind = KIND_LINE_END;
            r.width = w;
            r.quoted = q;
            r.is_header = hdr;
            fld_index = '0;
            clear_field();
            if (line_idx != 32'hFFFF_FFFF)
                line_idx = line_idx + 32'd1;
            return 1'b1;
        end
        if (c == CH_QUOTE)
        begin
            if (in_qrun)
                return 1'b0;
            in_qrun = 1'b1;
        end
        else
            in_qrun = 1'b0;
        r.kind = KIND_DATA;
        r.out_byte = c;
        r.field_number = fld_index[7:0];
        r.is_header = hdr;
        r.line_number = line_idx;
        if (fld_width == 0)
            first_is_q = (c == CH_QUOTE);
        last_is_q = (c == CH_QUOTE);
        if (fld_width != 16'hFFFF)
            fld_width = fld_width + 16'd1;
        return 1'b1;
    endfunction

    function automatic logic [7:0] text_byte();
        logic [7:0] b;
        b = 8'($urandom_range(255));
        if (b == CH_TAB || b == CH_NL || b == CH_QUOTE)
            b = b ^ 8'h40;
        return b;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        errors++;
        if (errors <= 60)
            $display("mismatch on %s: got %0h, expected %0h", what, got, want);
    endtask

    task automatic send_byte(input logic [7:0] b, input bit has_lit = 1'b0,
                             input result_t lit = '0);
        result_t r;
        if (idle_pct != 0 && $urandom_range(99) < idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < idle_pct);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= b;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        if (split_byte(b, r))
            predicted_tokens.push_back(has_lit ? lit : r);
        sent_count++;
    endtask

    task automatic wait_for_results();
        s_axis_tvalid <= 1'b0;
        while (predicted_tokens.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_save_header(input logic v);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= REG_SAVE_HEADER;
        pwdata <= {31'd0, v};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        hdr_mode = v;
        pwrite <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        if (prdata !== {31'd0, v})
            report_mismatch("save_header readback", prdata, {31'd0, v});
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic send_quote_run();
        repeat ($urandom_range(1, 3)) send_byte(CH_QUOTE);
    endtask

    task automatic send_line();
        int n;
        bit enclosed;
        for (int f = 0; f < LINE_FIELDS; f++)
        begin
            enclosed = 1'($urandom_range(1));
            n = $urandom_range(6);
            if (enclosed)
                send_quote_run();
            for (int k = 0; k < n; k++)
            begin
                if ($urandom_range(4) == 0)
                    send_quote_run();
                else
                    send_byte(text_byte());
            end
            if (enclosed)
                send_quote_run();
            send_byte(f == LINE_FIELDS - 1 ? CH_NL : CH_TAB);
        end
    endtask

    always @(posedge clk)
    begin
        if (hold_served != hold_requests)
        begin
            hold_served <= hold_requests;
            hold_left <= HOLD_CYCLES;
            m_axis_tready <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            m_axis_tready <= 1'b0;
        end
        else
            m_axis_tready <= ($urandom_range(99) >= stall_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got_r.kind = m_axis_tuser[1:0];
            got_r.is_header = m_axis_tuser[2];
            got_r.out_byte = m_axis_tdata[7:0];
            got_r.field_number = m_axis_tdata[15:8];
            got_r.width = m_axis_tdata[31:16];
            got_r.quoted = m_axis_tdata[32];
            got_r.field_count = m_axis_tdata[41:33];
            got_r.line_number = m_axis_tdata[73:42];
            if (predicted_tokens.size() == 0)
                report_mismatch("unexpected transfer, kind", got_r.kind, 0);
            else
            begin
                want_r = predicted_tokens.pop_front();
                if (got_r.kind !== want_r.kind)
                    report_mismatch("kind", got_r.kind, want_r.kind);
                if (got_r.out_byte !== want_r.out_byte)
                    report_mismatch("out_byte", got_r.out_byte, want_r.out_byte);
                if (got_r.field_number !== want_r.field_number)
                    report_mismatch("field_number", got_r.field_number, want_r.field_number);
                if (got_r.width !== want_r.width)
                    report_mismatch("width", got_r.width, want_r.width);
                if (got_r.quoted !== want_r.quoted)
                    report_mismatch("quoted", got_r.quoted, want_r.quoted);
                if (got_r.field_count !== want_r.field_count)
                    report_mismatch("field_count", got_r.field_count, want_r.field_count);
                if (got_r.is_header !== want_r.is_header)
                    report_mismatch("is_header", got_r.is_header, want_r.is_header);
                if (got_r.line_number !== want_r.line_number)
                    report_mismatch("line_number", got_r.line_number, want_r.line_number);
            end
        end
    end

    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("tb_tab_separated_field_splitter: done, errors");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        dir_rows = '{
            '{ROW_CFG,      8'd1,     '0},
            '{ROW_BYTE_LIT, 8'h00,    '{KIND_DATA, 8'h00, 8'd0, 16'd0, 1'b0, 9'd0, 1'b1, 32'd0}},
            '{ROW_BYTE_LIT, 8'hFF,    '{KIND_DATA, 8'hFF, 8'd0, 16'd0, 1'b0, 9'd0, 1'b1, 32'd0}},
            '{ROW_BYTE_LIT, CH_TAB,
                '{KIND_FIELD_END, 8'h00, 8'd0, 16'd2, 1'b0, 9'd0, 1'b1, 32'd0}},
            '{ROW_BYTE,     CH_QUOTE, '0},
            '{ROW_BYTE,     CH_QUOTE, '0},
            '{ROW_BYTE,     CH_QUOTE, '0},
            '{ROW_BYTE,     8'h61,    '0},
            '{ROW_BYTE,     CH_QUOTE, '0},
            '{ROW_BYTE,     CH_TAB,   '0},
            '{ROW_CFG,      8'd0,     '0},
            '{ROW_BYTE,     CH_QUOTE, '0},
            '{ROW_BYTE,     CH_TAB,   '0},
            '{ROW_BYTE_LIT, CH_NL,
                '{KIND_LINE_END, 8'h00, 8'd3, 16'd0, 1'b0, 9'd4, 1'b0, 32'd0}},
            '{ROW_BYTE,     CH_TAB,   '0},
            '{ROW_BYTE,     CH_QUOTE, '0},
            '{ROW_BYTE,     CH_QUOTE, '0},
            '{ROW_BYTE,     CH_TAB,   '0},
            '{ROW_BYTE,     8'h7F,    '0},
            '{ROW_BYTE,     CH_TAB,   '0},
            '{ROW_BYTE,     CH_NL,    '0}
        };
    end

    initial
    begin
        int target;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[i])
        begin
            case (dir_rows[i].op)
                ROW_CFG:
                begin
                    wait_for_results();
                    write_save_header(dir_rows[i].val[0]);
                end
                ROW_BYTE_LIT: send_byte(dir_rows[i].val, 1'b1, dir_rows[i].lit);
                default: send_byte(dir_rows[i].val);
            endcase
        end

        for (int ph = 0; ph < 4; ph++)
        begin
            wait_for_results();
            write_save_header(ph[0]);
            idle_pct = IDLE_PCT[ph];
            stall_pct = STALL_PCT[ph];
            if (ph == 2)
                hold_requests++;
            target = sent_count + PHASE_ITEMS;
            while (sent_count < target)
                send_line();
        end

        wait_for_results();
        idle_pct = 0;
        stall_pct = 0;

        // Too many fields: the line is rejected and the block stops for good.
        stall_pct = 34;
        repeat (MAXF + 44) send_byte(CH_TAB);
        send_byte(CH_NL);
        repeat (40) send_byte(8'($urandom_range(255)));
        send_byte(CH_NL);

        wait_for_results();
        repeat (6) @(posedge clk);
        if (errors == 0)
            $display("tb_tab_separated_field_splitter: done, clean");
        else
            $display("tb_tab_separated_field_splitter: done, errors");
        $finish;
    end

endmodule
